// ----- hdl/lpkt_pkg.sv -----
// Package with shared types and constants of the linear probing key table.
`default_nettype none
package lpkt_pkg;
  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_USED = 2'd1;
  localparam logic [1:0] MARK_GONE = 2'd2;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_MISS   = 3'd3;
  localparam logic [2:0] ST_BADKEY = 3'd4;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [10:0] SIZE_RESET = 11'd1021;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot;
    logic [15:0] record_number;
    logic [9:0]  collisions;
  } result_t;

  function automatic logic [7:0] key_byte(input logic [63:0] head, input int unsigned i);
    key_byte = head[63 - 8 * i -: 8];
  endfunction

  function automatic logic key_ok(input logic [63:0] head);
    logic ok;
    ok = 1'b1;
    for (int unsigned i = 0; i < 8; i++) begin
      if (key_byte(head, i) < 8'd48) ok = 1'b0;
    end
    key_ok = ok;
  endfunction

  // Weighted byte sum, at most 36 * 201, so 13 bits suffice.
  function automatic logic [12:0] key_sum(input logic [63:0] head);
    logic [12:0] s;
    logic [7:0]  b;
    logic [7:0]  m;
    s = '0;
    for (int unsigned i = 0; i < 8; i++) begin
      b = key_byte(head, i);
      m = (b < 8'd59) ? b - 8'd48 : b - 8'd54;
      s = s + 13'(m) * 13'(i + 1);
    end
    key_sum = s;
  endfunction
endpackage
`default_nettype wire

// ----- hdl/lpkt_ram.sv -----
// Generic single-port RAM with registered read data.
`default_nettype none
module lpkt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

// ----- hdl/lpkt_mod.sv -----
// Reduces the key sum modulo the table size one quotient bit per cycle.
`default_nettype none
module lpkt_mod #(
  parameter int AddrW = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [12:0]      sum_i,
  input  wire logic [AddrW:0]   size_i,
  output logic                  done_o,
  output logic      [AddrW-1:0] rem_o
);
  localparam int RemW = (AddrW + 1 > 13) ? AddrW + 1 : 13;
  logic [RemW-1:0] rem_q, rem_d;
  logic [RemW+12:0] div_q, div_d;
  logic [3:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [RemW+12:0] trial;

  always_comb begin
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = div_q << cnt_q;
    if (start_i) begin
      rem_d  = RemW'(sum_i);
      div_d  = (RemW + 13)'(size_i);
      cnt_d  = 4'd12;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ((RemW + 13)'(rem_q) >= trial) rem_d = rem_q - RemW'(trial);
      if (cnt_q == 4'd0) busy_d = 1'b0;
      else cnt_d = cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = busy_q && (cnt_q == 4'd0);
  assign rem_o  = AddrW'(rem_d);
endmodule
`default_nettype wire

// ----- hdl/linear_probe_key_table.sv -----
// Top level of the linear probing key table.
// An insert scans the slots in use for a duplicate, hashes the key and probes from its
// home slot; lookup and remove scan for the key. Slots are read one per cycle on the single port.
// One command is handled at a time; the result register frees once the word is taken.
// Reset clears the record counter and all slot marks through a clearing pass over the
// TABLE_DEPTH slots during which no command is accepted; table_size resets to 1021.
`default_nettype none
module linear_probe_key_table import lpkt_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [10:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // kind[1:0], key_head[65:2], key_tail[81:66], zero fill to 88 bits
  input  wire logic [87:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[2:0], slot[12:3], record_number[28:13], collisions[38:29], zero fill
  output logic      [39:0] m_axis_tdata
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int MW = 2 + 64 + 16 + 16;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_HASH  = 4'd3;
  localparam logic [3:0] S_PROBE = 4'd4;
  localparam logic [3:0] S_OUT   = 4'd5;
  localparam logic [3:0] S_WRITE = 4'd6;

  logic [3:0]    state_q, state_d;
  logic [10:0]   size_q;
  logic [AW:0]   n_q, n_d;
  logic [1:0]    kind_q, kind_d;
  logic [63:0]   head_q, head_d;
  logic [15:0]   tail_q, tail_d;
  logic [15:0]   count_q, count_d;
  logic [AW:0]   idx_q, idx_d;
  logic [AW-1:0] home_q, home_d;
  logic [AW:0]   col_q, col_d;
  logic          rd_q, rd_d;
  logic          first_q, first_d;
  result_t       res_q, res_d;
  logic          ovalid_q, ovalid_d;

  logic          we;
  logic [AW-1:0] addr;
  logic [MW-1:0] wdata, rdata;
  logic [1:0]    rmark;
  logic [63:0]   rhead;
  logic [15:0]   rtail, rrec;
  logic          hit;
  logic          mod_start, mod_done;
  logic [AW-1:0] mod_rem;
  logic [AW:0]   idx_next;
  logic [AW:0]   clamp;

  assign {rmark, rhead, rtail, rrec} = rdata;
  assign hit = (rmark == MARK_USED) && (rhead == head_q) && (rtail == tail_q);

  always_comb begin
    if (size_q < 11'd2) clamp = (AW + 1)'(2);
    else if (32'(size_q) > 32'(TABLE_DEPTH)) clamp = (AW + 1)'(TABLE_DEPTH);
    else clamp = (AW + 1)'(size_q);
  end

  lpkt_ram #(.Width(MW), .Depth(TABLE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  lpkt_mod #(.AddrW(AW)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .sum_i   (key_sum(head_q)),
    .size_i  (n_q),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, res_q.collisions, res_q.record_number, res_q.slot,
                          res_q.status};

  always_comb begin
    idx_next = idx_q + 1'b1;
    if (idx_next == n_q) idx_next = '0;
  end

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    kind_d    = kind_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    idx_d     = idx_q;
    home_d    = home_q;
    col_d     = col_q;
    rd_d      = 1'b0;
    first_d   = first_q;
    res_d     = res_q;
    ovalid_d  = ovalid_q;
    we        = 1'b0;
    addr      = idx_q[AW-1:0];
    wdata     = {MARK_USED, head_q, tail_q, count_q};
    mod_start = 1'b0;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
        idx_d = idx_q + 1'b1;
        if (idx_q == (AW + 1)'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
          idx_d   = '0;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          kind_d = s_axis_tdata[1:0];
          head_d = s_axis_tdata[65:2];
          tail_d = s_axis_tdata[81:66];
          n_d    = clamp;
          idx_d  = '0;
          addr   = '0;
          if (!key_ok(s_axis_tdata[65:2])) begin
            res_d    = '{ST_BADKEY, '0, '0, '0};
            ovalid_d = 1'b1;
          end else begin
            state_d = S_SCAN;
            rd_d    = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (rd_q) begin
          if (hit) begin
            if (kind_q == KIND_INSERT) begin
              res_d    = '{ST_DUP, '0, '0, '0};
              ovalid_d = 1'b1;
              state_d  = S_OUT;
            end else begin
              res_d = '{ST_DONE, 10'(idx_q), rrec, '0};
              if (kind_q == KIND_REMOVE) begin
                we    = 1'b1;
                wdata = {MARK_GONE, rhead, rtail, rrec};
              end
              ovalid_d = 1'b1;
              state_d  = S_OUT;
            end
          end else if (idx_q == n_q - 1'b1) begin
            if (kind_q != KIND_INSERT) begin
              res_d    = '{ST_MISS, '0, '0, '0};
              ovalid_d = 1'b1;
              state_d  = S_OUT;
            end else if (count_q == COUNT_MAX) begin
              res_d    = '{ST_FULL, '0, '0, '0};
              ovalid_d = 1'b1;
              state_d  = S_OUT;
            end else begin
              mod_start = 1'b1;
              state_d   = S_HASH;
            end
          end else begin
            idx_d = idx_q + 1'b1;
            addr  = idx_d[AW-1:0];
            rd_d  = 1'b1;
          end
        end else begin
          rd_d = 1'b1;
        end
      end
      S_HASH: begin
        if (mod_done) begin
          home_d  = mod_rem;
          idx_d   = {1'b0, mod_rem};
          addr    = mod_rem;
          col_d   = '0;
          first_d = 1'b1;
          rd_d    = 1'b1;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (rd_q) begin
          if (!first_q && idx_q[AW-1:0] == home_q) begin
            res_d    = '{ST_FULL, '0, '0, '0};
            ovalid_d = 1'b1;
            state_d  = S_OUT;
          end else if (rmark == MARK_USED) begin
            col_d   = col_q + 1'b1;
            first_d = 1'b0;
            idx_d   = idx_next;
            addr    = idx_next[AW-1:0];
            rd_d    = 1'b1;
          end else begin
            state_d = S_WRITE;
          end
        end else begin
          rd_d = 1'b1;
        end
      end
      S_WRITE: begin
        we       = 1'b1;
        res_d    = '{ST_DONE, 10'(idx_q), count_q, 10'(col_q)};
        ovalid_d = 1'b1;
        count_d  = count_q + 1'b1;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      size_q   <= SIZE_RESET;
      count_q  <= '0;
      idx_q    <= '0;
      rd_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) size_q <= cfg_wdata_i;
      count_q  <= count_d;
      idx_q    <= idx_d;
      rd_q     <= rd_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    kind_q  <= kind_d;
    head_q  <= head_d;
    tail_q  <= tail_d;
    home_q  <= home_d;
    col_q   <= col_d;
    first_q <= first_d;
    res_q   <= res_d;
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("accept while result pending");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + 16'd1))
    else $error("record counter jumped");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(res_q)) else $error("result changed");
endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the linear probing key table, with its own table predictor.
`default_nettype none
module tb;
  import lpkt_pkg::*;

  localparam int DEPTH = 1024;
  localparam int STALL_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [10:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  linear_probe_key_table dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Predicted table contents.
  logic [1:0]  tbl_mark [DEPTH];
  logic [63:0] tbl_head [DEPTH];
  logic [15:0] tbl_tail [DEPTH];
  logic [15:0] tbl_rec [DEPTH];
  int unsigned next_record;
  int unsigned size_reg;

  result_t     pending_results[$];
  int          errors;
  int          words_sent;
  int          words_checked;
  int          hold_cycles;
  bit          no_gaps;
  logic [63:0] key_pool_head [16];
  logic [15:0] key_pool_tail [16];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned slots_in_use();
    if (size_reg < 2) return 2;
    if (size_reg > DEPTH) return DEPTH;
    return size_reg;
  endfunction

  function automatic int unsigned find_slot(logic [63:0] head, logic [15:0] tail,
                                            int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (tbl_mark[i] == MARK_USED && tbl_head[i] == head && tbl_tail[i] == tail) return i;
    end
    return n;
  endfunction

  function automatic result_t model_command(logic [1:0] kind, logic [63:0] head,
                                            logic [15:0] tail);
    result_t     r;
    int unsigned n;
    int unsigned sum;
    int unsigned b;
    int unsigned home;
    int unsigned pos;
    int unsigned col;
    r = '0;
    n = slots_in_use();
    for (int i = 0; i < 8; i++) begin
      if (head[63 - 8 * i -: 8] < 8'd48) begin
        r.status = ST_BADKEY;
        return r;
      end
    end
    if (kind == KIND_INSERT) begin
      if (find_slot(head, tail, n) < n) begin
        r.status = ST_DUP;
        return r;
      end
      if (next_record >= COUNT_MAX) begin
        r.status = ST_FULL;
        return r;
      end
      sum = 0;
      for (int i = 0; i < 8; i++) begin
        b = head[63 - 8 * i -: 8];
        sum += (i + 1) * ((b < 59) ? b - 48 : b - 54);
      end
      home = sum % n;
      pos = home;
      col = 0;
      if (tbl_mark[home] == MARK_USED) begin
        col = 1;
        pos = (home + 1) % n;
        while (pos != home && tbl_mark[pos] == MARK_USED) begin
          pos = (pos + 1) % n;
          col++;
        end
        if (pos == home) begin
          r.status = ST_FULL;
          return r;
        end
      end
      tbl_mark[pos] = MARK_USED;
      tbl_head[pos] = head;
      tbl_tail[pos] = tail;
      tbl_rec[pos] = next_record[15:0];
      r.status = ST_DONE;
      r.slot = pos[9:0];
      r.record_number = next_record[15:0];
      r.collisions = col[9:0];
      next_record++;
      return r;
    end
    pos = find_slot(head, tail, n);
    if (pos >= n) begin
      r.status = ST_MISS;
      return r;
    end
    if (kind == KIND_REMOVE) tbl_mark[pos] = MARK_GONE;
    r.status = ST_DONE;
    r.slot = pos[9:0];
    r.record_number = tbl_rec[pos];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] good_head();
    logic [63:0] h;
    for (int i = 0; i < 8; i++) h[8 * i +: 8] = 8'($urandom_range(48, 255));
    return h;
  endfunction

  function automatic logic [63:0] bad_head();
    logic [63:0] h;
    h = good_head();
    h[8 * $urandom_range(0, 7) +: 8] = 8'($urandom_range(0, 47));
    return h;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch in %s: got %0d, expected %0d (word %0d)", what, got, want,
             words_checked);
    errors++;
  endtask

  task automatic send_word(logic [1:0] kind, logic [63:0] head, logic [15:0] tail);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, tail, head, kind};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(model_command(kind, head, tail));
    words_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(int unsigned value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value[10:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = value & 11'h7FF;
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, always ready when gaps are off, or one long hold-off when asked.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
        m_axis_tready <= 1'b1;
      end else if (no_gaps) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 19) < 14) ||
                         ($urandom_range(0, 9) == 0 && !m_axis_tready);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result word", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[2:0] !== want.status)
          report("status", m_axis_tdata[2:0], want.status);
        if (m_axis_tdata[12:3] !== want.slot)
          report("slot", m_axis_tdata[12:3], want.slot);
        if (m_axis_tdata[28:13] !== want.record_number)
          report("record number", m_axis_tdata[28:13], want.record_number);
        if (m_axis_tdata[38:29] !== want.collisions)
          report("collisions", m_axis_tdata[38:29], want.collisions);
      end
      words_checked++;
    end
  end

  // Watchdog on cycles with no word moving on either side.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
      if (idle >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed();
    logic [63:0] k;
    write_size(7);
    k = 64'h3132333435363738;
    send_word(KIND_INSERT, k, 16'h0000);
    send_word(KIND_INSERT, k, 16'h0000);
    send_word(KIND_LOOKUP, k, 16'h0000);
    send_word(KIND_LOOKUP, k, 16'hFFFF);
    send_word(2'd3, k, 16'h0000);
    send_word(KIND_INSERT, 64'h3030303030303030, 16'hFFFF);
    send_word(KIND_INSERT, 64'hFFFFFFFFFFFFFFFF, 16'hA5A5);
    send_word(KIND_INSERT, 64'h3B3B3B3B3A3A3A3A, 16'h5A5A);
    send_word(KIND_REMOVE, k, 16'h0000);
    send_word(KIND_LOOKUP, k, 16'h0000);
    send_word(KIND_REMOVE, k, 16'h0000);
    send_word(KIND_INSERT, k, 16'h0000);
    send_word(KIND_INSERT, 64'h2F30303030303030, 16'h0001);
    send_word(KIND_LOOKUP, 64'h303030303030302F, 16'h0001);
    send_word(KIND_REMOVE, 64'h0000000000000000, 16'h0001);
    // Fill the table until the probe wraps.
    for (int i = 0; i < 6; i++) send_word(KIND_INSERT, good_head(), 16'($urandom));
    send_word(KIND_LOOKUP, 64'hFFFFFFFFFFFFFFFF, 16'hA5A5);
  endtask

  task automatic test_size_limits();
    write_size(0);
    for (int i = 0; i < 3; i++) send_word(KIND_INSERT, good_head(), 16'($urandom));
    send_word(KIND_LOOKUP, 64'h3132333435363738, 16'h0000);
    write_size(2047);
    for (int i = 0; i < 3; i++) send_word(KIND_INSERT, good_head(), 16'($urandom));
    write_size(1024);
    send_word(KIND_INSERT, 64'hFFFFFFFFFFFFFFFF, 16'hA5A5);
    send_word(KIND_LOOKUP, 64'h3030303030303030, 16'hFFFF);
    write_size(2);
    send_word(KIND_INSERT, good_head(), 16'hFFFF);
    send_word(KIND_INSERT, good_head(), 16'h0000);
    write_size(1021);
    send_word(KIND_REMOVE, 64'hFFFFFFFFFFFFFFFF, 16'hA5A5);
  endtask

  task automatic test_random_mix(int unsigned size, int count);
    int          r;
    int          p;
    logic [1:0]  kind;
    logic [63:0] head;
    logic [15:0] tail;
    write_size(size);
    for (int i = 0; i < 16; i++) begin
      key_pool_head[i] = good_head();
      key_pool_tail[i] = 16'($urandom);
    end
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      kind = (r < 45) ? KIND_INSERT : (r < 75) ? KIND_LOOKUP : (r < 95) ? KIND_REMOVE : 2'd3;
      p = $urandom_range(0, 15);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        head = key_pool_head[p];
        tail = key_pool_tail[p];
      end else if (r < 93) begin
        head = good_head();
        tail = 16'($urandom);
      end else begin
        head = bad_head();
        tail = 16'($urandom);
      end
      send_word(kind, head, tail);
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 3000;
    for (int i = 0; i < 6; i++) send_word(KIND_INSERT, good_head(), 16'($urandom));
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    hold_cycles = 0;
    no_gaps = 1'b0;
    next_record = 0;
    size_reg = SIZE_RESET;
    for (int i = 0; i < DEPTH; i++) tbl_mark[i] = MARK_FREE;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_size_limits();
    test_random_mix(5, 40);
    no_gaps = 1'b1;
    test_random_mix(13, 40);
    no_gaps = 1'b0;
    test_random_mix(3, 35);
    test_random_mix(31, 40);
    test_random_mix(64, 40);
    test_random_mix(11, 35);
    test_random_mix(1024, 8);
    test_backpressure();
    drain();
    repeat (2200) @(posedge clk_i);
    $display("Sent %0d command words and checked %0d result words.", words_sent,
             words_checked);
    $display("Covered inserts, lookups, removes, bad keys, full tables and size limits.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
